[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_SAME(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/ajbt_pkg.sv]
package ajbt_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int GAIN_W     = 16;
	localparam int LAT_W      = 16;
	localparam int WINDOW_W   = 18;
	localparam int ACT_W      = 2;
	localparam int BLEN_W     = 13;
	localparam int DROP_W     = 16;
	localparam int FRAMES_W   = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;
	localparam int GAIN_FRAC  = 12;
	localparam int ROUND_BIAS = 2048;

	// Gain bands
	localparam logic [GAIN_W-1:0] UNITY_LO = 16'd4092;
	localparam logic [GAIN_W-1:0] UNITY_HI = 16'd4100;
	localparam logic [GAIN_W-1:0] MUTE_MAX = 16'd4;

	localparam logic signed [SAMPLE_W-1:0] S24_MAX = 24'sh7FFFFF;
	localparam logic signed [SAMPLE_W-1:0] S24_MIN = 24'sh800000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LATENCY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAPTURE     = 3'd4;

	// Register reset values
	localparam logic [GAIN_W-1:0]   GAIN_RST    = 16'd4096;
	localparam logic [LAT_W-1:0]    LATENCY_RST = 16'd882;
	localparam logic [WINDOW_W-1:0] WINDOW_RST  = 18'd132300;
	localparam logic [ACT_W-1:0]    ACTIVE_RST  = 2'd2;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_BLOCK = 2'd1,
		MODE_READ  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		FIN_EXEC  = 2'd0,
		FIN_TRIM  = 2'd1,
		FIN_COPY  = 2'd2,
		FIN_SCALE = 2'd3
	} fin_src_t;

	typedef struct packed {
		logic [1:0]                 mode;
		logic                       channel;
		logic signed [SAMPLE_W-1:0] in_sample;
		logic [BLEN_W-1:0]          block_len;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_sample;
		logic                       out_valid;
		logic                       underrun;
		logic                       overflow;
		logic [DROP_W-1:0]          dropped_frames;
	} out_item_t;

	typedef struct packed {
		logic [GAIN_W-1:0]   gain;
		logic [LAT_W-1:0]    max_latency;
		logic [WINDOW_W-1:0] check_window;
		logic [ACT_W-1:0]    active_channels;
		logic                capture_enable;
	} cfg_regs_t;

	typedef struct packed {
		logic     load;
		logic     exec;
		logic     trim_calc;
		logic     trim_apply;
		logic     mul;
		logic     fin;
		fin_src_t src;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_mem;
		logic blk_close;
		logic unity;
	} dp_status_t;

endpackage

[rtl/ajbt_cfg.sv]
module ajbt_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ajbt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ajbt_pkg::CFG_DATA_W-1:0] cfg_data,
	output ajbt_pkg::cfg_regs_t             regs
);
	import ajbt_pkg::*;

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.gain            <= GAIN_RST;
			regs_q.max_latency     <= LATENCY_RST;
			regs_q.check_window    <= WINDOW_RST;
			regs_q.active_channels <= ACTIVE_RST;
			regs_q.capture_enable  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN:        regs_q.gain            <= cfg_data[GAIN_W-1:0];
				REG_MAX_LATENCY: regs_q.max_latency     <= cfg_data[LAT_W-1:0];
				REG_WINDOW:      regs_q.check_window    <= cfg_data[WINDOW_W-1:0];
				REG_ACTIVE:      regs_q.active_channels <= cfg_data[ACT_W-1:0];
				REG_CAPTURE:     regs_q.capture_enable  <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/ajbt_ctrl.sv]
`include "assert_macros.svh"

module ajbt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  ajbt_pkg::dp_status_t   status,
	output ajbt_pkg::ctrl_cmd_t    cmd
);
	import ajbt_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EXEC   = 6'b000010,
		S_TCALC  = 6'b000100,
		S_TAPPLY = 6'b001000,
		S_RDWAIT = 6'b010000,
		S_SAT    = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.src        = FIN_EXEC;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (status.need_mem) begin
					state_d = S_RDWAIT;
				end else if (status.blk_close) begin
					state_d = S_TCALC;
				end else begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_TCALC: begin
				cmd.trim_calc = 1'b1;
				state_d       = S_TAPPLY;
			end
			S_TAPPLY: begin
				cmd.trim_apply = 1'b1;
				cmd.fin        = 1'b1;
				cmd.src        = FIN_TRIM;
				state_d        = S_IDLE;
			end
			S_RDWAIT: begin
				if (status.unity) begin
					cmd.fin = 1'b1;
					cmd.src = FIN_COPY;
					state_d = S_IDLE;
				end else begin
					cmd.mul = 1'b1;
					state_d = S_SAT;
				end
			end
			S_SAT: begin
				cmd.fin = 1'b1;
				cmd.src = FIN_SCALE;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`ASSERT_NEXT(a_fin_idle, cmd.fin, !busy, "controller not idle after finishing a word")
	`ASSERT_NEXT(a_load_exec, cmd.load, cmd.exec, "load not followed by execute")

endmodule

[rtl/ajbt_dp.sv]
`include "assert_macros.svh"

module ajbt_dp #(
	parameter int CHANNELS   = 2,
	parameter int FIFO_DEPTH = 32768
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ajbt_pkg::in_item_t   item,
	input  ajbt_pkg::cfg_regs_t  cfg,
	input  ajbt_pkg::ctrl_cmd_t  cmd,
	output ajbt_pkg::dp_status_t status,
	output logic                 done,
	output ajbt_pkg::out_item_t  result
);
	import ajbt_pkg::*;

	localparam int PW        = $clog2(FIFO_DEPTH);
	localparam int FW        = $clog2(FIFO_DEPTH + 1);
	localparam int EW        = (FW > LAT_W) ? FW : LAT_W;
	localparam int SW        = PW + 2;
	localparam int MEM_DEPTH = CHANNELS * FIFO_DEPTH;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam int PRW       = SAMPLE_W + GAIN_W + 1;

	in_item_t                   item_q;
	logic [PW-1:0]              wp_q   [CHANNELS];
	logic [PW-1:0]              rp_q   [CHANNELS];
	logic [FW-1:0]              fill_q [CHANNELS];
	logic [FW-1:0]              min_fill_q;
	logic [FRAMES_W-1:0]        frames_q;
	logic [EW-1:0]              excess_q;
	logic signed [SAMPLE_W-1:0] rd_data_q;
	logic signed [PRW-1:0]      prod_q;
	logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
	logic                       done_q;
	out_item_t                  result_q;
	out_item_t                  result_d;

	logic [PW-1:0]              wp_cur, rp_cur, wp_inc, rp_inc;
	logic [FW-1:0]              fill_cur;
	logic [ACT_W-1:0]           act;
	logic                       ch_active, is_mute, is_unity, fifo_full, fifo_empty;
	logic                       is_wr, is_blk, is_rd;
	logic                       do_write, wr_overflow, do_pop, rd_under, need_mem, blk_go;
	logic [AW-1:0]              base, wr_addr, rd_addr;
	logic                       win_open, win_close;
	logic [FRAMES_W-1:0]        frames_next;
	logic [FW-1:0]              min_next;
	logic [FW-1:0]              trim_n  [CHANNELS];
	logic [PW-1:0]              trim_rp [CHANNELS];
	logic [SW-1:0]              trim_sum [CHANNELS];
	logic signed [PRW-1:0]      biased, shifted;
	logic signed [SAMPLE_W-1:0] sat_sample;

	// Select the addressed channel's pointers and fill.
	always_comb begin
		fill_cur = '0;
		wp_cur   = '0;
		rp_cur   = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (c == int'(item_q.channel)) begin
				fill_cur = fill_q[c];
				wp_cur   = wp_q[c];
				rp_cur   = rp_q[c];
			end
		end
	end

	assign act = (int'(cfg.active_channels) > CHANNELS) ? ACT_W'(CHANNELS)
							    : cfg.active_channels;
	assign ch_active  = ({1'b0, item_q.channel} < act);
	assign is_mute    = (cfg.gain <= MUTE_MAX);
	assign is_unity   = (cfg.gain >= UNITY_LO) && (cfg.gain <= UNITY_HI);
	assign fifo_full  = (fill_cur == FW'(FIFO_DEPTH));
	assign fifo_empty = (fill_cur == '0);

	assign is_wr  = (item_q.mode == MODE_WRITE);
	assign is_blk = (item_q.mode == MODE_BLOCK);
	assign is_rd  = (item_q.mode == MODE_READ);

	assign do_write    = is_wr && cfg.capture_enable && ch_active && !fifo_full;
	assign wr_overflow = is_wr && cfg.capture_enable && ch_active && fifo_full;
	assign do_pop      = is_rd && ch_active && !fifo_empty;
	assign rd_under    = is_rd && ch_active && !is_mute && fifo_empty;
	assign need_mem    = do_pop && !is_mute;
	assign blk_go      = is_blk && (act != '0);

	assign wp_inc = (wp_cur == PW'(FIFO_DEPTH - 1)) ? '0 : wp_cur + PW'(1);
	assign rp_inc = (rp_cur == PW'(FIFO_DEPTH - 1)) ? '0 : rp_cur + PW'(1);

	assign base    = item_q.channel ? AW'(FIFO_DEPTH) : '0;
	assign wr_addr = base + AW'(wp_cur);
	assign rd_addr = base + AW'(rp_cur);

	// Window tracking on channel-0 fill
	assign win_open    = (frames_q == '0);
	assign frames_next = win_open ? FRAMES_W'(item_q.block_len)
				      : frames_q + FRAMES_W'(item_q.block_len);
	assign min_next    = win_open ? fill_q[0]
				      : ((fill_q[0] < min_fill_q) ? fill_q[0] : min_fill_q);
	assign win_close   = (frames_next >= FRAMES_W'(cfg.check_window));

	assign status.need_mem  = need_mem;
	assign status.blk_close = blk_go && win_close;
	assign status.unity     = is_unity;

	// Trim amount and new read pointer per channel
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			trim_n[c]   = (excess_q < EW'(fill_q[c])) ? FW'(excess_q) : fill_q[c];
			trim_sum[c] = SW'(rp_q[c]) + SW'(trim_n[c]);
			trim_rp[c]  = (trim_sum[c] >= SW'(FIFO_DEPTH))
				      ? PW'(trim_sum[c] - SW'(FIFO_DEPTH)) : PW'(trim_sum[c]);
		end
	end

	// Round half up, then saturate.
	assign biased  = prod_q + PRW'(ROUND_BIAS);
	assign shifted = biased >>> GAIN_FRAC;
	always_comb begin
		if (shifted > S24_MAX) begin
			sat_sample = S24_MAX;
		end else if (shifted < S24_MIN) begin
			sat_sample = S24_MIN;
		end else begin
			sat_sample = shifted[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.trim_calc) begin
			excess_q <= (EW'(min_fill_q) > EW'(cfg.max_latency))
				    ? EW'(min_fill_q) - EW'(cfg.max_latency) : '0;
		end
		if (cmd.mul) begin
			prod_q <= rd_data_q * $signed({1'b0, cfg.gain});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && do_write) begin
			mem[wr_addr] <= item_q.in_sample;
		end
		if (cmd.exec && need_mem) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				wp_q[c]   <= '0;
				rp_q[c]   <= '0;
				fill_q[c] <= '0;
			end
			min_fill_q <= '0;
			frames_q   <= '0;
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (cmd.exec && (c == int'(item_q.channel))) begin
					if (do_write) begin
						wp_q[c]   <= wp_inc;
						fill_q[c] <= fill_cur + FW'(1);
					end
					if (do_pop) begin
						rp_q[c]   <= rp_inc;
						fill_q[c] <= fill_cur - FW'(1);
					end
				end
				if (cmd.trim_apply && (c < int'(act))) begin
					rp_q[c]   <= trim_rp[c];
					fill_q[c] <= fill_q[c] - trim_n[c];
				end
			end
			if (cmd.exec && blk_go) begin
				min_fill_q <= min_next;
				frames_q   <= win_close ? '0 : frames_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin;
		end
	end

	// Build the result word for the finishing step.
	always_comb begin
		result_d = '0;
		unique case (cmd.src)
			FIN_EXEC: begin
				result_d.out_valid = is_rd && ch_active;
				result_d.underrun  = rd_under;
				result_d.overflow  = wr_overflow;
			end
			FIN_TRIM: result_d.dropped_frames = excess_q[DROP_W-1:0];
			FIN_COPY: begin
				result_d.out_sample = rd_data_q;
				result_d.out_valid  = 1'b1;
			end
			FIN_SCALE: begin
				result_d.out_sample = sat_sample;
				result_d.out_valid  = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	for (genvar c = 0; c < CHANNELS; c++) begin : g_fill_chk
		`ASSERT_ALWAYS(a_fill_bound, fill_q[c] <= FW'(FIFO_DEPTH), "fill exceeds depth")
	end
	`ASSERT_SAME(a_under_zero, done && result.underrun, result.out_valid && result.out_sample == '0, "underrun word not zero valid")
	`ASSERT_SAME(a_flag_excl, done && result.overflow, !result.out_valid && result.dropped_frames == '0, "overflow mixed with other results")

endmodule

[rtl/audio_jitter_buffer_latency_trim_unit.sv]
// Channel    Handshake                 Word
// item       start / busy              ajbt_pkg::in_item_t  (mode, channel, sample, length)
// result     done (one-cycle strobe)   ajbt_pkg::out_item_t (sample, flags, dropped frames)
// config     cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A word is taken when start is high and busy is low; its result word shows on result
// for exactly one cycle with done high, and the receiver cannot stall it.
// Writes, plain block starts, muted or empty reads and unused modes finish from the
// execute step; unity-gain reads add a memory read; scaled reads add the memory read,
// multiply, then round and saturate; window-closing block starts add excess, then trim.
// busy drops in the cycle the result is strobed, so the next word goes in alongside it.
// Reset is asynchronous, active low; pointers, fills and window state clear at once,
// the sample memory holds no reset value and needs no clearing pass.
module audio_jitter_buffer_latency_trim_unit #(
	parameter int CHANNELS   = 2,
	parameter int FIFO_DEPTH = 32768
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  ajbt_pkg::in_item_t              item,
	output logic                            done,
	output ajbt_pkg::out_item_t             result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ajbt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ajbt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ajbt_pkg::*;

	cfg_regs_t  regs;
	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Register file: gain, latency limit, window, channel count, capture gate.
	ajbt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// Sequencer: load the word, execute, then trim or fetch and copy or scale as needed.
	ajbt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	// FIFO pointers, fills, window tracking, sample memory, gain multiply.
	ajbt_dp #(
		.CHANNELS   (CHANNELS),
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (regs),
		.cmd    (cmd),
		.status (status),
		.done   (done),
		.result (result)
	);

endmodule

[sim/tb_audio_jitter_buffer_latency_trim_unit.sv]
module tb_audio_jitter_buffer_latency_trim_unit;
	import ajbt_pkg::*;

	localparam int NUM_CH      = 2;
	localparam int DEPTH       = 32768;
	localparam int PTR_W       = $clog2(DEPTH);
	localparam int RAND_WORDS  = 1800;
	localparam int FILL_WORDS  = 40;
	localparam int PHASES      = 6;
	localparam int STEADY_PH   = 2;
	localparam int PAUSE_PH    = 3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_REPORTS = 40;
	localparam int TAIL_CYCLES = 8;
	localparam int IDLE_PCT    = 35;

	// Mode code the block leaves unused; it must answer with an all-zero word.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	in_item_t              item      = '0;
	logic                  done;
	out_item_t             result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_GAIN;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	audio_jitter_buffer_latency_trim_unit #(
		.CHANNELS   (NUM_CH),
		.FIFO_DEPTH (DEPTH)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Free-running clock, period 12.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the jitter buffer: sample FIFOs, fills, trim window
	// and the register file. Updated at the edge where a word is taken.
	// ------------------------------------------------------------------
	logic [SAMPLE_W-1:0] fifo_mem [NUM_CH*DEPTH];
	logic [PTR_W-1:0]    wr_ptr   [NUM_CH];
	logic [PTR_W-1:0]    rd_ptr   [NUM_CH];
	logic [15:0]         fill     [NUM_CH];
	logic [15:0]         win_min;
	logic [FRAMES_W-1:0] win_frames;
	cfg_regs_t           regs;

	// Result words owed by the block, oldest first.
	out_item_t owed_results [$];

	bit          steady = 1'b0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	// One row of the directed table: either a register write or a word,
	// the latter optionally with its result word spelled out.
	typedef struct packed {
		logic                  is_reg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		in_item_t              w;
		logic                  given;
		out_item_t             want;
	} step_t;

	function automatic in_item_t word_of(logic [1:0] m, logic ch, logic [SAMPLE_W-1:0] s,
			logic [BLEN_W-1:0] b);
		in_item_t w;
		w.mode      = m;
		w.channel   = ch;
		w.in_sample = s;
		w.block_len = b;
		return w;
	endfunction

	function automatic out_item_t res(logic [SAMPLE_W-1:0] s, logic v, logic u, logic o,
			logic [DROP_W-1:0] d);
		out_item_t r;
		r.out_sample     = s;
		r.out_valid      = v;
		r.underrun       = u;
		r.overflow       = o;
		r.dropped_frames = d;
		return r;
	endfunction

	function automatic step_t do_word(logic [1:0] m, logic ch, logic [SAMPLE_W-1:0] s,
			logic [BLEN_W-1:0] b);
		step_t t;
		t        = '0;
		t.w      = word_of(m, ch, s, b);
		return t;
	endfunction

	function automatic step_t do_check(logic [1:0] m, logic ch, logic [SAMPLE_W-1:0] s,
			logic [BLEN_W-1:0] b, out_item_t e);
		step_t t;
		t       = do_word(m, ch, s, b);
		t.given = 1'b1;
		t.want  = e;
		return t;
	endfunction

	function automatic step_t do_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		step_t t;
		t         = '0;
		t.is_reg  = 1'b1;
		t.reg_idx = idx;
		t.reg_val = val;
		return t;
	endfunction

	// Pop the oldest sample of a channel from the shadow FIFO.
	function automatic logic [SAMPLE_W-1:0] pop_sample(logic ch);
		logic [SAMPLE_W-1:0] v;
		v = fifo_mem[{ch, rd_ptr[ch]}];
		rd_ptr[ch]++;
		fill[ch]--;
		return v;
	endfunction

	// Apply one word to the shadow buffer and return the result word it yields.
	function automatic out_item_t advance_buffers(in_item_t w);
		out_item_t           r;
		int                  act;
		int                  c;
		logic [15:0]         excess;
		logic [15:0]         cut;
		logic [SAMPLE_W-1:0] raw;
		longint              prod;
		r   = '0;
		// Active-channel count above the channel total saturates to it.
		act = (regs.active_channels > NUM_CH) ? NUM_CH : int'(regs.active_channels);
		case (w.mode)
		MODE_WRITE: begin
			// Drop writes while capture is off or to an idle channel, silently.
			if (regs.capture_enable && w.channel < act) begin
				if (fill[w.channel] >= DEPTH) begin
					r.overflow = 1'b1;
				end else begin
					fifo_mem[{w.channel, wr_ptr[w.channel]}] = w.in_sample;
					wr_ptr[w.channel]++;
					fill[w.channel]++;
				end
			end
		end
		MODE_BLOCK: begin
			if (act > 0) begin
				// Open a window on the first block, else track the channel-0 minimum.
				if (win_frames == '0) begin
					win_min    = fill[0];
					win_frames = FRAMES_W'(w.block_len);
				end else begin
					if (fill[0] < win_min)
						win_min = fill[0];
					win_frames = win_frames + FRAMES_W'(w.block_len);
				end
				// Close the window; trim the excess from every active channel,
				// clamped to what each one holds.
				if (win_frames >= FRAMES_W'(regs.check_window)) begin
					win_frames = '0;
					if (win_min > regs.max_latency) begin
						excess = win_min - regs.max_latency;
						for (c = 0; c < act; c++) begin
							cut       = (excess < fill[c]) ? excess : fill[c];
							rd_ptr[c] = rd_ptr[c] + PTR_W'(cut);
							fill[c]   = fill[c] - cut;
						end
						r.dropped_frames = excess;
					end
				end
			end
		end
		MODE_READ: begin
			if (w.channel < act) begin
				r.out_valid = 1'b1;
				if (regs.gain <= MUTE_MAX) begin
					// Mute: advance the FIFO if it holds anything, emit silence.
					if (fill[w.channel] != '0)
						raw = pop_sample(w.channel);
				end else if (fill[w.channel] == '0) begin
					r.underrun = 1'b1;
				end else begin
					raw = pop_sample(w.channel);
					if (regs.gain >= UNITY_LO && regs.gain <= UNITY_HI) begin
						r.out_sample = raw;
					end else begin
						// Q1.23 x Q4.12, round half up, floor shift, saturate.
						prod = (longint'(signed'(raw)) * longint'(regs.gain) + ROUND_BIAS)
							>>> GAIN_FRAC;
						if (prod > S24_MAX)
							prod = S24_MAX;
						else if (prod < S24_MIN)
							prod = S24_MIN;
						r.out_sample = SAMPLE_W'(prod);
					end
				end
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Hold start low while the owed results drain; the block is idle after.
	task automatic drain();
		if (start)
			start <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	// Present one word and hold it until the block takes it. Idle a random
	// number of cycles first unless in the steady stretch.
	task automatic send_word(in_item_t w, logic given = 1'b0, out_item_t want = '0);
		out_item_t calc;
		cfg_valid <= 1'b0;
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < IDLE_PCT);
		end
		start <= 1'b1;
		item  <= w;
		do
			@(posedge clk);
		while (busy);
		// Word taken at this edge: advance the shadow and owe its result.
		calc = advance_buffers(w);
		owed_results.push_back(given ? want : calc);
	endtask

	// Write one register. Leave cfg_valid up; the next word lowers it.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
		REG_GAIN:        regs.gain            = val[GAIN_W-1:0];
		REG_MAX_LATENCY: regs.max_latency     = val[LAT_W-1:0];
		REG_WINDOW:      regs.check_window    = val[WINDOW_W-1:0];
		REG_ACTIVE:      regs.active_channels = val[ACT_W-1:0];
		REG_CAPTURE:     regs.capture_enable  = val[0];
		default: ;
		endcase
	endtask

	// Drain, then load the whole register file.
	task automatic apply_settings(logic [CFG_DATA_W-1:0] g, logic [CFG_DATA_W-1:0] lat,
			logic [CFG_DATA_W-1:0] win, logic [CFG_DATA_W-1:0] act, logic [CFG_DATA_W-1:0] cap);
		drain();
		write_reg(REG_GAIN, g);
		write_reg(REG_MAX_LATENCY, lat);
		write_reg(REG_WINDOW, win);
		write_reg(REG_ACTIVE, act);
		write_reg(REG_CAPTURE, cap);
	endtask

	// Random word: mostly writes and reads in a balance set per phase,
	// some block starts, a little unused-mode noise.
	function automatic in_item_t random_word(int write_pct);
		logic [1:0]          m;
		logic [SAMPLE_W-1:0] s;
		logic [BLEN_W-1:0]   b;
		int                  r;
		r = $urandom_range(99);
		if (r < 4)
			m = MODE_UNUSED;
		else if (r < 4 + write_pct)
			m = MODE_WRITE;
		else if (r < 88)
			m = MODE_READ;
		else
			m = MODE_BLOCK;
		case ($urandom_range(9))
		0:       s = S24_MAX;
		1:       s = S24_MIN;
		default: s = SAMPLE_W'($urandom);
		endcase
		case ($urandom_range(19))
		0:       b = '0;
		1:       b = BLEN_W'(4096);
		2:       b = '1;
		3:       b = BLEN_W'($urandom_range(8191));
		default: b = BLEN_W'($urandom_range(1, 16));
		endcase
		return word_of(m, 1'($urandom_range(1)), s, b);
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// ------------------------------------------------------------------
	// Result checker: every strobed word must match the oldest owed one.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t unexpected result word: expected none, actual %h",
						$time, result);
			end else begin
				want = owed_results.pop_front();
				check_field("out_sample", want.out_sample, result.out_sample);
				check_field("out_valid", want.out_valid, result.out_valid);
				check_field("underrun", want.underrun, result.underrun);
				check_field("overflow", want.overflow, result.overflow);
				check_field("dropped_frames", want.dropped_frames, result.dropped_frames);
			end
		end
	end

	// Watchdog: end the run if it stalls.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** audio_jitter_buffer_latency_trim_unit: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		step_t                 steps [$];
		logic [CFG_DATA_W-1:0] g, lat, win, act, cap;
		int                    pct;
		out_item_t             zero;

		zero = '0;
		// Shadow state matches the block after reset.
		for (int c = 0; c < NUM_CH; c++) begin
			wr_ptr[c] = '0;
			rd_ptr[c] = '0;
			fill[c]   = '0;
		end
		win_min               = '0;
		win_frames            = '0;
		regs.gain             = GAIN_RST;
		regs.max_latency      = LATENCY_RST;
		regs.check_window     = WINDOW_RST;
		regs.active_channels  = ACTIVE_RST;
		regs.capture_enable   = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Rows with a result word spelled out are checked
		// against it; the rest go through the shadow model.
		steps = '{
			// Capture off after reset: drop the write without flags.
			do_check(MODE_WRITE, 1'b0, S24_MAX, 1, zero),
			// Empty read at unity gain flags underrun.
			do_check(MODE_READ, 1'b0, '0, 1, res('0, 1'b1, 1'b1, 1'b0, '0)),
			// Unused mode answers with all zeros.
			do_check(MODE_UNUSED, 1'b1, S24_MIN, '1, zero),
			do_reg(REG_CAPTURE, 1),
			do_check(MODE_WRITE, 1'b0, S24_MAX, 1, zero),
			do_check(MODE_WRITE, 1'b0, S24_MIN, 1, zero),
			do_check(MODE_WRITE, 1'b1, 24'h000001, 1, zero),
			// Unity gain copies the full-scale sample.
			do_check(MODE_READ, 1'b0, '0, 1, res(S24_MAX, 1'b1, 1'b0, 1'b0, '0)),
			// Top gain saturates negative full scale.
			do_reg(REG_GAIN, 65535),
			do_check(MODE_READ, 1'b0, '0, 1, res(S24_MIN, 1'b1, 1'b0, 1'b0, '0)),
			do_word(MODE_READ, 1'b1, '0, 1),
			do_check(MODE_READ, 1'b1, '0, 1, res('0, 1'b1, 1'b1, 1'b0, '0)),
			// Mute: pop and emit silence, and no underrun on an empty FIFO.
			do_reg(REG_GAIN, 0),
			do_check(MODE_WRITE, 1'b0, 24'h123456, 1, zero),
			do_check(MODE_READ, 1'b0, '0, 1, res('0, 1'b1, 1'b0, 1'b0, '0)),
			do_check(MODE_READ, 1'b0, '0, 1, res('0, 1'b1, 1'b0, 1'b0, '0)),
			// Just above the mute band an empty read is an underrun again.
			do_reg(REG_GAIN, 5),
			do_check(MODE_READ, 1'b0, '0, 1, res('0, 1'b1, 1'b1, 1'b0, '0)),
			// Lower edge of the unity band copies.
			do_reg(REG_GAIN, 4092),
			do_check(MODE_WRITE, 1'b0, 24'hABCDEF, 1, zero),
			do_check(MODE_READ, 1'b0, '0, 1, res(24'hABCDEF, 1'b1, 1'b0, 1'b0, '0)),
			// One active channel: channel 1 ignores writes and reads.
			do_reg(REG_ACTIVE, 1),
			do_check(MODE_WRITE, 1'b1, 24'h555555, 1, zero),
			do_check(MODE_READ, 1'b1, '0, 1, zero),
			// Count above the channel total acts as all channels.
			do_reg(REG_ACTIVE, 3),
			do_check(MODE_READ, 1'b1, '0, 1, res('0, 1'b1, 1'b1, 1'b0, '0)),
			// No active channels: block start and read do nothing.
			do_reg(REG_ACTIVE, 0),
			do_check(MODE_BLOCK, 1'b0, '0, '1, zero),
			do_check(MODE_READ, 1'b0, '0, 1, zero),
			// Zero window with zero latency: a zero-length block closes the
			// window and trims the single buffered frame.
			do_reg(REG_ACTIVE, 2),
			do_reg(REG_MAX_LATENCY, 0),
			do_reg(REG_WINDOW, 0),
			do_check(MODE_WRITE, 1'b0, 24'h0F0F0F, 1, zero),
			do_check(MODE_BLOCK, 1'b0, '0, '0, res('0, 1'b0, 1'b0, 1'b0, 16'd1))
		};
		foreach (steps[i]) begin
			if (steps[i].is_reg) begin
				drain();
				write_reg(steps[i].reg_idx, steps[i].reg_val);
			end else begin
				send_word(steps[i].w, steps[i].given, steps[i].want);
			end
		end

		// Buffer a short run on channel 0, with a few frames on channel 1 to
		// exercise the clamped trim.
		apply_settings(GAIN_RST, FILL_WORDS, 1, 2, 1);
		repeat (10)
			send_word(word_of(MODE_WRITE, 1'b1, SAMPLE_W'($urandom), 1));
		for (int i = 0; i < FILL_WORDS; i++)
			send_word(word_of(MODE_WRITE, 1'b0, SAMPLE_W'($urandom), 1));
		// Minimum equals the limit: close the window without trimming.
		send_word(word_of(MODE_BLOCK, 1'b0, '0, 1));
		// Zero limit: drop everything buffered in one trim.
		drain();
		write_reg(REG_MAX_LATENCY, 0);
		send_word(word_of(MODE_BLOCK, 1'b0, '0, 1));

		// Random phases, each under fresh register settings.
		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(7))
			0:       g = 0;
			1:       g = MUTE_MAX;
			2:       g = UNITY_LO;
			3:       g = UNITY_HI;
			4:       g = 65535;
			5:       g = GAIN_RST;
			default: g = $urandom_range(65535);
			endcase
			case ($urandom_range(5))
			0:       lat = 0;
			1:       lat = DEPTH;
			2:       lat = 65535;
			default: lat = $urandom_range(24);
			endcase
			case ($urandom_range(5))
			0:       win = 0;
			1:       win = 1;
			2:       win = 262143;
			default: win = $urandom_range(1, 48);
			endcase
			// Open with the widest window so the top register value is seen.
			if (p == 0)
				win = 262143;
			case ($urandom_range(9))
			0:       act = 0;
			1:       act = 1;
			2:       act = 3;
			default: act = 2;
			endcase
			cap = ($urandom_range(9) != 0);
			pct = $urandom_range(30, 60);
			apply_settings(g, lat, win, act, cap);
			steady = (p == STEADY_PH);
			for (int i = 0; i < RAND_WORDS / PHASES; i++) begin
				// Hold the sender once mid-phase until every result is back.
				if (p == PAUSE_PH && i == RAND_WORDS / PHASES / 2)
					drain();
				send_word(random_word(pct));
			end
		end
		steady = 1'b0;

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** audio_jitter_buffer_latency_trim_unit: PASSED **");
		else
			$display("** audio_jitter_buffer_latency_trim_unit: FAILED **");
		$finish;
	end

endmodule
